>>> hdl/htwd_pkg.sv
// shared types and constants for the huffman tree-walk decoder
// no dependencies; imported by huffman_tree_walk_decoder_core
package htwd_pkg;

    localparam int NODE_COUNT = 512;
    localparam int COUNT_BITS = 32;
    localparam int NODE_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SIZE_BITS  = 32;
    localparam int CMP_W      = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;
    localparam int BYTE_BITS  = 8;
    localparam int BCNT_W     = $clog2(BYTE_BITS + 1);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [8:0] node_index;
        logic       node_is_leaf;
        logic [8:0] left_child;
        logic [8:0] right_child;
        logic [7:0] leaf_symbol;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       finished;
    } out_t;

    typedef struct packed {
        logic       leaf;
        logic [8:0] left;
        logic [8:0] right;
        logic [7:0] sym;
    } node_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

>>> hdl/huffman_tree_walk_decoder_core.sv
// huffman tree-walk decoder: node table memory, bit-serial walk, result staging
// depends on htwd_pkg
//
//  channel | dir | handshake          | transaction
//  in      | in  | in_valid/in_ready  | node load, data byte or stream start
//  out     | out | out_valid/out_ready| one decoded symbol
//  cfg     | in  | cfg_we             | write of original_size
//
// node loads and starts are handled in idle; a data byte is walked in steps: one to
// accept and read the current node, up to eight bit steps each doing one node-table
// read, one step for the final leaf check and one to hand over the last symbol. the
// dependent node-table read per bit sets the one bit per cycle pace unless stalled.
// reset clears walk position, symbol count, original_size and all valid flags;
// the node table is not cleared. a full output register holds the walk in place.
module huffman_tree_walk_decoder_core
    import htwd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_t                 out_data,
    input  logic                 cfg_we,
    input  logic [SIZE_BITS-1:0] cfg_wdata
);

    state_t                 state_reg, state_next;
    logic [NODE_AW-1:0]     pos_reg, pos_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [SIZE_BITS-1:0]   size_reg;
    logic [BYTE_BITS-1:0]   shift_reg, shift_next;
    logic [BCNT_W-1:0]      bits_reg, bits_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   rd_first_reg, rd_first_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [7:0]             pend_sym_reg, pend_sym_next;
    logic                   pend_fin_reg, pend_fin_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_reg, out_next;
    node_t                  root_reg, root_next;

    node_t                  node_mem [NODE_COUNT];
    node_t                  rd_data_reg;
    logic                   rd_en;
    logic [NODE_AW-1:0]     rd_addr;
    logic                   mem_we;
    logic [NODE_AW-1:0]     wr_addr;
    node_t                  wr_node;

    logic                   slot_free;
    logic                   leaf_hit;
    node_t                  cur_node;
    logic [8:0]             child_raw;
    logic [NODE_AW-1:0]     child;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [COUNT_BITS-1:0]  cnt_after;
    logic                   leaf_fin;
    logic                   stream_done;
    logic                   stall;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign wr_addr = in_data.node_index[NODE_AW-1:0];
    assign wr_node = '{leaf:  in_data.node_is_leaf,
                       left:  in_data.left_child,
                       right: in_data.right_child,
                       sym:   in_data.leaf_symbol};

    assign slot_free = !out_valid_reg || out_ready;
    assign leaf_hit  = rd_valid_reg && !rd_first_reg && rd_data_reg.leaf;
    assign cur_node  = leaf_hit ? root_reg : rd_data_reg;
    assign child_raw = shift_reg[BYTE_BITS-1] ? cur_node.right : cur_node.left;
    assign child     = (int'(child_raw) >= NODE_COUNT) ? '0 : child_raw[NODE_AW-1:0];

    assign cnt_inc     = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_after   = leaf_hit ? cnt_inc : cnt_reg;
    assign leaf_fin    = (CMP_W'(cnt_inc) == CMP_W'(size_reg));
    assign stream_done = (CMP_W'(cnt_after) >= CMP_W'(size_reg));
    assign stall       = leaf_hit && pend_valid_reg && !slot_free;

    // node table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[wr_addr] <= wr_node;
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            size_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            rd_valid_reg   <= rd_valid_next;
            rd_first_reg   <= rd_first_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bits_reg     <= bits_next;
        pend_sym_reg <= pend_sym_next;
        pend_fin_reg <= pend_fin_next;
        out_reg      <= out_next;
        root_reg     <= root_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        shift_next      = shift_reg;
        bits_next       = bits_reg;
        rd_valid_next   = rd_valid_reg;
        rd_first_next   = rd_first_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_fin_next   = pend_fin_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        root_next       = root_reg;
        rd_en           = 1'b0;
        rd_addr         = pos_reg;
        mem_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.req_type)
                        REQ_LOAD:
                        begin
                            if (int'(in_data.node_index) < NODE_COUNT)
                            begin
                                mem_we = 1'b1;
                                if (in_data.node_index == '0)
                                begin
                                    root_next = wr_node;
                                end
                            end
                        end
                        REQ_START:
                        begin
                            pos_next = '0;
                            cnt_next = '0;
                        end
                        REQ_DATA:
                        begin
                            // fetch the node at the current position first
                            shift_next    = in_data.data_byte;
                            bits_next     = BCNT_W'(BYTE_BITS);
                            rd_en         = 1'b1;
                            rd_addr       = pos_reg;
                            rd_valid_next = 1'b1;
                            rd_first_next = 1'b1;
                            state_next    = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!stall)
                begin
                    rd_valid_next = 1'b0;
                    rd_first_next = 1'b0;
                    if (leaf_hit)
                    begin
                        cnt_next        = cnt_inc;
                        pos_next        = '0;
                        pend_valid_next = 1'b1;
                        pend_sym_next   = rd_data_reg.sym;
                        pend_fin_next   = leaf_fin;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{symbol: pend_sym_reg, last: 1'b0,
                                               finished: pend_fin_reg};
                        end
                    end
                    if ((bits_reg != '0) && !stream_done)
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = child;
                        pos_next      = child;
                        rd_valid_next = 1'b1;
                        shift_next    = {shift_reg[BYTE_BITS-2:0], 1'b0};
                        bits_next     = bits_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                // last symbol of the byte
                if (pend_valid_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_next        = '{symbol: pend_sym_reg, last: 1'b1,
                                            finished: pend_fin_reg};
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
